// ===== design/rgb256_pkg.sv =====
// Shared types and constants for the RGB to 256-color index pipeline.
package rgb256_pkg;

    localparam logic [7:0] LVL0_LIMIT   = 8'd47;   // below this a channel sits at cube level 0
    localparam logic [7:0] CUBE_ORIGIN  = 8'd75;   // 0x5f - 20
    localparam logic [7:0] CUBE_STEP    = 8'd40;
    localparam logic [7:0] NEAR_LO      = 8'd18;
    localparam logic [7:0] NEAR_HI      = 8'd22;
    localparam logic [7:0] GRAY_LIMIT   = 8'd4;    // below this the gray step is -1
    localparam logic [7:0] GRAY_ORIGIN  = 8'd3;    // 0x08 - 5
    localparam logic [15:0] GRAY_RECIP  = 16'd205; // 2048 / 10, exact for inputs up to 252
    localparam int          GRAY_SHIFT  = 11;
    localparam logic signed [5:0] GRAY_LAST = 6'sd23;
    localparam logic [7:0] CUBE_ROW     = 8'd36;
    localparam logic [7:0] CUBE_COL     = 8'd6;
    localparam logic [7:0] INDEX_BASE   = 8'd16;
    localparam logic [7:0] WHITE_INDEX  = 8'd231;
    localparam logic [7:0] GRAY_BASE    = 8'd232;

    typedef struct packed {
        logic [2:0]        lvl;
        logic              near;
        logic signed [5:0] gs;
    } chan_feat_t;

    typedef struct packed {
        logic       use_gray;
        logic [7:0] cube_idx;
        logic [7:0] gray_idx;
    } pick_t;

endpackage

// ===== design/rgb256_chan.sv =====
// Per-channel quantizer: cube level, near-level flag and gray step.
module rgb256_chan (
    input  logic [7:0]              pix,
    output rgb256_pkg::chan_feat_t  feat
);
    import rgb256_pkg::*;

    logic [7:0]  u;
    logic [7:0]  r;
    logic [15:0] prod;

    always_comb begin
        u    = pix - CUBE_ORIGIN;
        r    = u;
        prod = 16'(pix - GRAY_ORIGIN) * GRAY_RECIP;
        feat.near = 1'b0;
        if (pix < LVL0_LIMIT) begin
            feat.lvl = 3'd0;
        end else if (pix < CUBE_ORIGIN) begin
            feat.lvl = 3'd1;
        end else begin
            if (u >= 8'(4 * CUBE_STEP)) begin
                feat.lvl = 3'd5;
                r = u - 8'(4 * CUBE_STEP);
            end else if (u >= 8'(3 * CUBE_STEP)) begin
                feat.lvl = 3'd4;
                r = u - 8'(3 * CUBE_STEP);
            end else if (u >= 8'(2 * CUBE_STEP)) begin
                feat.lvl = 3'd3;
                r = u - 8'(2 * CUBE_STEP);
            end else if (u >= CUBE_STEP) begin
                feat.lvl = 3'd2;
                r = u - CUBE_STEP;
            end else begin
                feat.lvl = 3'd1;
            end
            feat.near = (r >= NEAR_LO) && (r <= NEAR_HI);
        end
        if (pix < GRAY_LIMIT) begin
            feat.gs = -6'sd1;
        end else begin
            feat.gs = $signed({1'b0, prod[GRAY_SHIFT +: 5]});
        end
    end

endmodule

// ===== design/rgb256_pick.sv =====
// Decides between cube color, kept cube color and gray ramp entry.
module rgb256_pick (
    input  rgb256_pkg::chan_feat_t  fr,
    input  rgb256_pkg::chan_feat_t  fg,
    input  rgb256_pkg::chan_feat_t  fb,
    output rgb256_pkg::pick_t       pick
);
    import rgb256_pkg::*;

    logic              kept;
    logic              lvl_ok;
    logic              gs_ok;
    logic [2:0]        la;
    logic [2:0]        lb;
    logic signed [5:0] ga;
    logic signed [5:0] gb;
    logic signed [6:0] gd;

    always_comb begin
        kept = (fr.lvl == fg.lvl) && (fg.lvl == fb.lvl) && fr.near && fg.near && fb.near;

        if (fg.lvl == fb.lvl) begin
            la = fr.lvl;
            lb = fg.lvl;
        end else begin
            la = fg.lvl;
            lb = fb.lvl;
        end
        lvl_ok = ((fr.lvl == fg.lvl) || (la == fb.lvl)) &&
                 ((la == lb) || ({1'b0, la} == {1'b0, lb} + 4'd1) ||
                  ({1'b0, lb} == {1'b0, la} + 4'd1));

        if (fg.gs == fb.gs) begin
            ga = fr.gs;
            gb = fg.gs;
        end else begin
            ga = fg.gs;
            gb = fb.gs;
        end
        gd    = 7'(ga) - 7'(gb);
        gs_ok = ((fr.gs == fg.gs) || (ga == fb.gs)) && (gd >= -7'sd2) && (gd <= 7'sd2);

        // gray step comes from red when green and blue agree, else green
        if (ga < 6'sd0) begin
            pick.gray_idx = INDEX_BASE;
        end else if (ga > GRAY_LAST) begin
            pick.gray_idx = WHITE_INDEX;
        end else begin
            pick.gray_idx = GRAY_BASE + 8'(ga[4:0]);
        end

        pick.cube_idx = INDEX_BASE + 8'(fr.lvl) * CUBE_ROW + 8'(fg.lvl) * CUBE_COL
                        + 8'(fb.lvl);
        pick.use_gray = !kept && lvl_ok && gs_ok;
    end

endmodule

// ===== design/rgb24_to_256_color_index_unit.sv =====
// Top level: three-stage pipeline mapping an RGB pixel to a 256-color index.
// The channel features, the pick and the index are registered in turn before m_tvalid.
// Throughput: one pixel per cycle; the three stage registers each take a new
// pixel whenever the stage after them is empty or moving.
// Reset: synchronous, active low; clears all stage valid bits, no payload reset.
// A stalled result holds while earlier stages keep filling their empty slots.
module rgb24_to_256_color_index_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // color_index [7:0]
);
    import rgb256_pkg::*;

    chan_feat_t fr_next, fg_next, fb_next;
    chan_feat_t fr_reg, fg_reg, fb_reg;
    pick_t      pick_next, pick_reg;
    logic [7:0] idx_next, idx_reg;
    logic       v1_reg, v2_reg, v3_reg;
    logic       rdy1, rdy2, rdy3;

    rgb256_chan u_chan_r (.pix(s_tdata[7:0]),   .feat(fr_next));
    rgb256_chan u_chan_g (.pix(s_tdata[15:8]),  .feat(fg_next));
    rgb256_chan u_chan_b (.pix(s_tdata[23:16]), .feat(fb_next));

    rgb256_pick u_pick (.fr(fr_reg), .fg(fg_reg), .fb(fb_reg), .pick(pick_next));

    assign idx_next = pick_reg.use_gray ? pick_reg.gray_idx : pick_reg.cube_idx;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            fr_reg <= fr_next;
            fg_reg <= fg_next;
            fb_reg <= fb_next;
        end
        if (rdy2 && v1_reg) begin
            pick_reg <= pick_next;
        end
        if (rdy3 && v2_reg) begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== design/rgb256_chk.sv =====
// Port-level checker for the color index unit, bound to the top level.
module rgb256_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // stalled input transfer holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input changed while stalled");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata >= 8'd16)
        else $error("index below palette range");

    // empty output stage means the whole pipe can move
    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rgb24_to_256_color_index_unit rgb256_chk u_rgb256_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
